>>> sv/cvm_pkg.sv
package cvm_pkg;

    localparam int QW    = 32;
    localparam int FRAC  = 16;
    localparam int UW    = 18;
    localparam int MW    = 32;
    localparam int SQW   = 64;
    localparam int LW    = 32;
    localparam int QB    = 17;
    localparam int NUMW  = MW + FRAC;
    localparam int IN_W  = 9 * QW;
    localparam int OUT_W = 12 * QW;

    localparam logic [SQW-1:0] MAG_LIM  = 64'h0000_0000_8000_0000;
    localparam logic [QW-1:0]  HALF_LSB = 32'h0000_8000;
    localparam logic [QW-1:0]  SAT_MAX  = 32'h7fff_ffff;
    localparam logic [QW-1:0]  SAT_MIN  = 32'h8000_0000;

    typedef logic [2:0][UW-1:0] t_uvec;
    typedef logic [2:0][QW-1:0] t_qvec;

endpackage

>>> sv/cvm_sqrt.sv
module cvm_sqrt #(
    parameter int SW = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [cvm_pkg::SQW-1:0]    i_rad,
    input  logic [SW-1:0]              i_side,
    output logic                       o_valid,
    output logic [cvm_pkg::LW-1:0]     o_root,
    output logic [SW-1:0]              o_side
);
    import cvm_pkg::*;

    localparam int NS = SQW / 2;
    localparam int RW = LW + 2;

    logic           r_vld  [NS];
    logic [SQW-1:0] r_x    [NS];
    logic [RW-1:0]  r_rem  [NS];
    logic [LW-1:0]  r_q    [NS];
    logic [SW-1:0]  r_side [NS];

    for (genvar i = 0; i < NS; i++) begin : g_st
        logic           w_v;
        logic [SQW-1:0] w_x;
        logic [RW-1:0]  w_rem;
        logic [LW-1:0]  w_q;
        logic [SW-1:0]  w_side;
        logic [RW+1:0]  w_r2;
        logic [RW+1:0]  w_trial;

        if (i == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_x    = i_rad;
            assign w_rem  = '0;
            assign w_q    = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_vld[i-1];
            assign w_x    = r_x[i-1];
            assign w_rem  = r_rem[i-1];
            assign w_q    = r_q[i-1];
            assign w_side = r_side[i-1];
        end

        assign w_r2    = {w_rem, w_x[SQW-1 -: 2]};
        assign w_trial = {2'b00, w_q, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i]    <= {w_x[SQW-3:0], 2'b00};
                r_side[i] <= w_side;
                if (w_r2 >= w_trial) begin
                    r_rem[i] <= RW'(w_r2 - w_trial);
                    r_q[i]   <= {w_q[LW-2:0], 1'b1};
                end else begin
                    r_rem[i] <= RW'(w_r2);
                    r_q[i]   <= {w_q[LW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_root  = r_q[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

>>> sv/cvm_div.sv
module cvm_div #(
    parameter int SW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [cvm_pkg::LW-1:0]      i_len,
    input  logic [2:0][cvm_pkg::MW-1:0] i_mag,
    input  logic [2:0]                  i_neg,
    input  logic [SW-1:0]               i_side,
    output logic                        o_valid,
    output cvm_pkg::t_uvec              o_unit,
    output logic [SW-1:0]               o_side
);
    import cvm_pkg::*;

    logic            r_v0;
    logic [NUMW-1:0] r_num0 [3];
    logic [LW-1:0]   r_len0;
    logic [2:0]      r_neg0;
    logic            r_zero0;
    logic [SW-1:0]   r_side0;

    logic            r_vs   [QB];
    logic [LW-1:0]   r_rem  [QB][3];
    logic [QB-1:0]   r_low  [QB][3];
    logic [QB-1:0]   r_quo  [QB][3];
    logic [LW-1:0]   r_len  [QB];
    logic [2:0]      r_neg  [QB];
    logic            r_zero [QB];
    logic [SW-1:0]   r_side [QB];

    logic            r_vo;
    t_uvec           r_unit;
    logic [SW-1:0]   r_sideo;

    // numerator with rounding half of the length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_num0[j] <= {i_mag[j], {FRAC{1'b0}}} + NUMW'(i_len >> 1);
            end
            r_len0  <= i_len;
            r_neg0  <= i_neg;
            r_zero0 <= (i_len == '0);
            r_side0 <= i_side;
        end
    end

    for (genvar i = 0; i < QB; i++) begin : g_st
        logic          w_v;
        logic [LW-1:0] w_rem [3];
        logic [QB-1:0] w_low [3];
        logic [QB-1:0] w_quo [3];
        logic [LW-1:0] w_len;
        logic [2:0]    w_neg;
        logic          w_zero;
        logic [SW-1:0] w_side;
        logic [LW:0]   w_r2  [3];

        if (i == 0) begin : g_first
            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    w_rem[j] = LW'(r_num0[j][NUMW-1:QB]);
                    w_low[j] = r_num0[j][QB-1:0];
                    w_quo[j] = '0;
                end
            end
            assign w_v    = r_v0;
            assign w_len  = r_len0;
            assign w_neg  = r_neg0;
            assign w_zero = r_zero0;
            assign w_side = r_side0;
        end else begin : g_next
            always_comb begin
                for (int j = 0; j < 3; j++) begin
                    w_rem[j] = r_rem[i-1][j];
                    w_low[j] = r_low[i-1][j];
                    w_quo[j] = r_quo[i-1][j];
                end
            end
            assign w_v    = r_vs[i-1];
            assign w_len  = r_len[i-1];
            assign w_neg  = r_neg[i-1];
            assign w_zero = r_zero[i-1];
            assign w_side = r_side[i-1];
        end

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                w_r2[j] = {w_rem[j], w_low[j][QB-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[i] <= 1'b0;
            end else if (i_en) begin
                r_vs[i] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int j = 0; j < 3; j++) begin
                    if (w_r2[j] >= {1'b0, w_len}) begin
                        r_rem[i][j] <= LW'(w_r2[j] - {1'b0, w_len});
                        r_quo[i][j] <= {w_quo[j][QB-2:0], 1'b1};
                    end else begin
                        r_rem[i][j] <= LW'(w_r2[j]);
                        r_quo[i][j] <= {w_quo[j][QB-2:0], 1'b0};
                    end
                    r_low[i][j] <= {w_low[j][QB-2:0], 1'b0};
                end
                r_len[i]  <= w_len;
                r_neg[i]  <= w_neg;
                r_zero[i] <= w_zero;
                r_side[i] <= w_side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_vs[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                if (r_zero[QB-1]) begin
                    r_unit[j] <= '0;
                end else if (r_neg[QB-1][j]) begin
                    r_unit[j] <= -{1'b0, r_quo[QB-1][j]};
                end else begin
                    r_unit[j] <= {1'b0, r_quo[QB-1][j]};
                end
            end
            r_sideo <= r_side[QB-1];
        end
    end

    assign o_valid = r_vo;
    assign o_unit  = r_unit;
    assign o_side  = r_sideo;

endmodule

>>> sv/cvm_norm.sv
module cvm_norm #(
    parameter int W  = 32,
    parameter int SW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [2:0][W-1:0]  i_vec,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    output cvm_pkg::t_uvec     o_unit,
    output logic [SW-1:0]      o_side
);
    import cvm_pkg::*;

    localparam int NK  = (W > MW) ? W - MW + 1 : 1;
    localparam int KW  = (NK > 1) ? $clog2(NK) : 1;
    localparam int QSW = 3 * MW + 3 + SW;

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic [W-1:0]   r_m1 [3];
    logic [W-1:0]   r_m2 [3];
    logic [W-1:0]   r_m3 [3];
    logic [MW-1:0]  r_m4 [3];
    logic [MW-1:0]  r_m5 [3];
    logic [MW-1:0]  r_m6 [3];
    logic [2:0]     r_n1, r_n2, r_n3, r_n4, r_n5, r_n6;
    logic [SW-1:0]  r_s1, r_s2, r_s3, r_s4, r_s5, r_s6;
    logic [W-1:0]   n_mx;
    logic [W-1:0]   r_mx2;
    logic [KW-1:0]  n_k;
    logic [KW-1:0]  r_k3;
    logic [SQW-1:0] r_sq5 [3];
    logic [SQW-1:0] r_sum6;

    logic             w_sq_v;
    logic [LW-1:0]    w_len;
    logic [QSW-1:0]   w_sq_side;
    logic [2:0][MW-1:0] w_mag;
    logic [2:0]       w_neg;
    logic [SW-1:0]    w_side;

    always_comb begin
        n_mx = r_m1[0];
        if (r_m1[1] > n_mx) begin
            n_mx = r_m1[1];
        end
        if (r_m1[2] > n_mx) begin
            n_mx = r_m1[2];
        end
    end

    // smallest shift that brings the largest magnitude down to 2^31
    always_comb begin
        n_k = '0;
        for (int k = NK - 1; k >= 0; k--) begin
            if ((r_mx2 >> k) <= W'(MAG_LIM)) begin
                n_k = KW'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_n1[j]  <= i_vec[j][W-1];
                r_m1[j]  <= i_vec[j][W-1] ? W'(-i_vec[j]) : i_vec[j];
                r_m2[j]  <= r_m1[j];
                r_m3[j]  <= r_m2[j];
                r_m4[j]  <= MW'(r_m3[j] >> r_k3);
                r_sq5[j] <= {{(SQW-MW){1'b0}}, r_m4[j]} * {{(SQW-MW){1'b0}}, r_m4[j]};
                r_m5[j]  <= r_m4[j];
                r_m6[j]  <= r_m5[j];
            end
            r_mx2  <= n_mx;
            r_k3   <= n_k;
            r_sum6 <= r_sq5[0] + r_sq5[1] + r_sq5[2];
            r_n2 <= r_n1;
            r_n3 <= r_n2;
            r_n4 <= r_n3;
            r_n5 <= r_n4;
            r_n6 <= r_n5;
            r_s1 <= i_side;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            r_s4 <= r_s3;
            r_s5 <= r_s4;
            r_s6 <= r_s5;
        end
    end

    cvm_sqrt #(
        .SW (QSW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v6),
        .i_rad   (r_sum6),
        .i_side  ({r_m6[2], r_m6[1], r_m6[0], r_n6, r_s6}),
        .o_valid (w_sq_v),
        .o_root  (w_len),
        .o_side  (w_sq_side)
    );

    assign {w_mag, w_neg, w_side} = w_sq_side;

    cvm_div #(
        .SW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (w_sq_v),
        .i_len   (w_len),
        .i_mag   (w_mag),
        .i_neg   (w_neg),
        .i_side  (w_side),
        .o_valid (o_valid),
        .o_unit  (o_unit),
        .o_side  (o_side)
    );

endmodule

>>> sv/camera_view_matrix_core.sv
// channel   dir  signals                                   word
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready/tdata     look, right hint, eye (9 x q16.16)
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready/tdata     right, up, fwd, 3 shifts (12 x q16.16)
//
// one word per cycle while the pipeline is not stalled
// three normalizers in series, each 6 magnitude stages, a 32 stage square root
// and a 19 stage divider
// synchronous active-low reset clears the valid bits only
// a held output stalls the pipeline unless the stage ahead of the output register holds a bubble
module camera_view_matrix_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // look_x, look_y, look_z, right_x, right_y, right_z, eye_x, eye_y, eye_z
    input  logic [cvm_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // basis_right_x/y/z, basis_up_x/y/z, basis_fwd_x/y/z,
    // shift_right, shift_up, shift_fwd
    output logic [cvm_pkg::OUT_W-1:0]   o_m_axis_tdata
);
    import cvm_pkg::*;

    localparam int PW1 = UW + QW;
    localparam int XW1 = PW1 + 1;
    localparam int PW2 = 2 * UW;
    localparam int XW2 = PW2 + 1;
    localparam int DW  = PW1 + 2;
    localparam int RDW = DW - FRAC + 1;
    localparam int ASW = 6 * QW;
    localparam int BSW = 3 * QW + 3 * UW;
    localparam int CSW = 3 * QW + 6 * UW;

    logic w_en;
    logic w_out_free;

    // first normalize: look
    logic            w_a_v;
    t_uvec           w_fwd_a;
    logic [ASW-1:0]  w_a_side;
    t_qvec           w_rh_a;
    t_qvec           w_eye_a;

    logic                  r_c1_v;
    logic signed [PW1-1:0] r_c1_p [6];
    t_uvec                 r_c1_fwd;
    t_qvec                 r_c1_eye;

    logic                  r_c2_v;
    logic [2:0][XW1-1:0]   r_c2_x;
    t_uvec                 r_c2_fwd;
    t_qvec                 r_c2_eye;

    // second normalize: up
    logic            w_b_v;
    t_uvec           w_up_b;
    logic [BSW-1:0]  w_b_side;
    t_uvec           w_fwd_b;
    t_qvec           w_eye_b;

    logic                  r_c3_v;
    logic signed [PW2-1:0] r_c3_p [6];
    t_uvec                 r_c3_up;
    t_uvec                 r_c3_fwd;
    t_qvec                 r_c3_eye;

    logic                  r_c4_v;
    logic [2:0][XW2-1:0]   r_c4_x;
    t_uvec                 r_c4_up;
    t_uvec                 r_c4_fwd;
    t_qvec                 r_c4_eye;

    // third normalize: right
    logic            w_c_v;
    t_uvec           w_rgt_c;
    logic [CSW-1:0]  w_c_side;
    t_uvec           w_up_c;
    t_uvec           w_fwd_c;
    t_qvec           w_eye_c;

    logic                  r_d1_v;
    logic signed [PW1-1:0] r_d1_p [9];
    logic [2:0][2:0][UW-1:0] r_d1_bas;

    logic                  r_d2_v;
    logic signed [DW-1:0]  r_d2_s [3];
    logic [2:0][2:0][UW-1:0] r_d2_bas;

    logic                  r_d3_v;
    logic [2:0]            r_d3_neg;
    logic [RDW-1:0]        r_d3_r [3];
    logic [2:0][2:0][UW-1:0] r_d3_bas;
    logic [2:0]            n_neg;
    logic [DW-1:0]         n_mag [3];
    logic [RDW-1:0]        n_rnd [3];

    t_qvec                 n_shift;
    logic [OUT_W-1:0]      n_data;
    logic                  r_out_v;
    logic [OUT_W-1:0]      r_out_data;

    assign w_out_free      = !r_out_v || i_m_axis_tready;
    assign w_en            = w_out_free || !r_d3_v;
    assign o_s_axis_tready = w_en;

    cvm_norm #(
        .W  (QW),
        .SW (ASW)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_vec   (i_s_axis_tdata[3*QW-1:0]),
        .i_side  (i_s_axis_tdata[9*QW-1:3*QW]),
        .o_valid (w_a_v),
        .o_unit  (w_fwd_a),
        .o_side  (w_a_side)
    );

    assign {w_eye_a, w_rh_a} = w_a_side;

    // fwd x right hint
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
        end else if (w_en) begin
            r_c1_v <= w_a_v;
            r_c2_v <= r_c1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1_p[0] <= $signed(w_fwd_a[1]) * $signed(w_rh_a[2]);
            r_c1_p[1] <= $signed(w_fwd_a[2]) * $signed(w_rh_a[1]);
            r_c1_p[2] <= $signed(w_fwd_a[2]) * $signed(w_rh_a[0]);
            r_c1_p[3] <= $signed(w_fwd_a[0]) * $signed(w_rh_a[2]);
            r_c1_p[4] <= $signed(w_fwd_a[0]) * $signed(w_rh_a[1]);
            r_c1_p[5] <= $signed(w_fwd_a[1]) * $signed(w_rh_a[0]);
            r_c1_fwd  <= w_fwd_a;
            r_c1_eye  <= w_eye_a;
            r_c2_x[0] <= XW1'(r_c1_p[0]) - XW1'(r_c1_p[1]);
            r_c2_x[1] <= XW1'(r_c1_p[2]) - XW1'(r_c1_p[3]);
            r_c2_x[2] <= XW1'(r_c1_p[4]) - XW1'(r_c1_p[5]);
            r_c2_fwd  <= r_c1_fwd;
            r_c2_eye  <= r_c1_eye;
        end
    end

    cvm_norm #(
        .W  (XW1),
        .SW (BSW)
    ) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c2_v),
        .i_vec   (r_c2_x),
        .i_side  ({r_c2_eye, r_c2_fwd}),
        .o_valid (w_b_v),
        .o_unit  (w_up_b),
        .o_side  (w_b_side)
    );

    assign {w_eye_b, w_fwd_b} = w_b_side;

    // up x fwd
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3_v <= 1'b0;
            r_c4_v <= 1'b0;
        end else if (w_en) begin
            r_c3_v <= w_b_v;
            r_c4_v <= r_c3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c3_p[0] <= $signed(w_up_b[1]) * $signed(w_fwd_b[2]);
            r_c3_p[1] <= $signed(w_up_b[2]) * $signed(w_fwd_b[1]);
            r_c3_p[2] <= $signed(w_up_b[2]) * $signed(w_fwd_b[0]);
            r_c3_p[3] <= $signed(w_up_b[0]) * $signed(w_fwd_b[2]);
            r_c3_p[4] <= $signed(w_up_b[0]) * $signed(w_fwd_b[1]);
            r_c3_p[5] <= $signed(w_up_b[1]) * $signed(w_fwd_b[0]);
            r_c3_up   <= w_up_b;
            r_c3_fwd  <= w_fwd_b;
            r_c3_eye  <= w_eye_b;
            r_c4_x[0] <= XW2'(r_c3_p[0]) - XW2'(r_c3_p[1]);
            r_c4_x[1] <= XW2'(r_c3_p[2]) - XW2'(r_c3_p[3]);
            r_c4_x[2] <= XW2'(r_c3_p[4]) - XW2'(r_c3_p[5]);
            r_c4_up   <= r_c3_up;
            r_c4_fwd  <= r_c3_fwd;
            r_c4_eye  <= r_c3_eye;
        end
    end

    cvm_norm #(
        .W  (XW2),
        .SW (CSW)
    ) u_norm_rgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c4_v),
        .i_vec   (r_c4_x),
        .i_side  ({r_c4_eye, r_c4_fwd, r_c4_up}),
        .o_valid (w_c_v),
        .o_unit  (w_rgt_c),
        .o_side  (w_c_side)
    );

    assign {w_eye_c, w_fwd_c, w_up_c} = w_c_side;

    // translation: negated dot products, rounded and saturated
    always_comb begin
        for (int b = 0; b < 3; b++) begin
            n_neg[b] = r_d2_s[b][DW-1];
            n_mag[b] = n_neg[b] ? DW'(-r_d2_s[b]) : DW'(r_d2_s[b]);
            n_rnd[b] = RDW'(({1'b0, n_mag[b]} + (DW+1)'(HALF_LSB)) >> FRAC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v <= 1'b0;
            r_d2_v <= 1'b0;
            r_d3_v <= 1'b0;
        end else if (w_en) begin
            r_d1_v <= w_c_v;
            r_d2_v <= r_d1_v;
            r_d3_v <= r_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_d1_p[j]     <= $signed(w_rgt_c[j]) * $signed(w_eye_c[j]);
                r_d1_p[3 + j] <= $signed(w_up_c[j]) * $signed(w_eye_c[j]);
                r_d1_p[6 + j] <= $signed(w_fwd_c[j]) * $signed(w_eye_c[j]);
            end
            r_d1_bas <= {w_fwd_c, w_up_c, w_rgt_c};
            for (int b = 0; b < 3; b++) begin
                r_d2_s[b] <= DW'(r_d1_p[3*b]) + DW'(r_d1_p[3*b + 1])
                             + DW'(r_d1_p[3*b + 2]);
                r_d3_r[b] <= n_rnd[b];
            end
            r_d2_bas <= r_d1_bas;
            r_d3_neg <= n_neg;
            r_d3_bas <= r_d2_bas;
        end
    end

    always_comb begin
        n_data = '0;
        for (int b = 0; b < 3; b++) begin
            if (r_d3_neg[b]) begin
                n_shift[b] = (r_d3_r[b] > RDW'(SAT_MAX)) ? SAT_MAX : QW'(r_d3_r[b]);
            end else begin
                n_shift[b] = (r_d3_r[b] > RDW'(SAT_MIN)) ? SAT_MIN : QW'(-r_d3_r[b]);
            end
            for (int j = 0; j < 3; j++) begin
                n_data[(3*b + j)*QW +: QW] = QW'($signed(r_d3_bas[b][j]));
            end
            n_data[(9 + b)*QW +: QW] = n_shift[b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_free) begin
            r_out_v <= r_d3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= n_data;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;

endmodule
